/* sv/afk_pkg.sv */
// ----------------------------------------------------------------------------
// afk_pkg
// Shared types, constants and arithmetic helpers of the arm forward
// kinematics block.
// ----------------------------------------------------------------------------
package afk_pkg;

  localparam int BASE_YAW_DEG = 0;
  localparam int BASE_DEG     = ((BASE_YAW_DEG % 360) + 360) % 360;
  localparam int BASE_FULL    = (BASE_DEG * 262144 + 180) / 360;
  localparam int BASE_HALF    = (BASE_DEG * 131072 + 180) / 360;

  localparam logic [30:0] C1 = 31'd1686629713;
  localparam logic [30:0] C3 = 31'd693598668;
  localparam logic [30:0] C5 = 31'd85569273;
  localparam logic [30:0] C7 = 31'd5026995;
  localparam logic [30:0] C9 = 31'd172271;
  localparam logic [30:0] ONE_Q30 = 31'd1073741824;

  localparam logic [17:0] QUARTER  = 18'd65536;
  localparam logic [19:0] DIV3_MUL = 20'd349526;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic [2:0] REG_BASE_X     = 3'd0;
  localparam logic [2:0] REG_BASE_Z     = 3'd1;
  localparam logic [2:0] REG_SHOULDER   = 3'd2;
  localparam logic [2:0] REG_PAN_CENTER = 3'd3;
  localparam logic [2:0] REG_LINK_A     = 3'd4;
  localparam logic [2:0] REG_LINK_B     = 3'd5;
  localparam logic [2:0] REG_LINK_C     = 3'd6;
  localparam logic [2:0] REG_TOOL       = 3'd7;

  localparam int NBODY = 5;
  localparam logic [2:0] BODY_LAST  = 3'd4;
  localparam logic [2:0] ACCEPT_GAP = 3'd4;
  localparam int PIPE_DEPTH = 14;

  localparam int NTRIG = 20;
  localparam int T_CA  = 0;
  localparam int T_SA  = 1;
  localparam int T_CB  = 2;
  localparam int T_SB  = 3;
  localparam int T_CC  = 4;
  localparam int T_SC  = 5;
  localparam int T_CY  = 6;
  localparam int T_SY  = 7;
  localparam int T_CBH = 8;
  localparam int T_SBH = 9;
  localparam int T_CPA = 10;
  localparam int T_SPA = 11;
  localparam int T_CTA = 12;
  localparam int T_STA = 13;
  localparam int T_CTB = 14;
  localparam int T_STB = 15;
  localparam int T_CTC = 16;
  localparam int T_STC = 17;
  localparam int T_CPB = 18;
  localparam int T_SPB = 19;

  typedef logic signed [31:0] trig_t;
  typedef logic signed [23:0] pos_t;

  typedef struct packed {
    logic signed [31:0] w;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } quat_t;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
  } vec2_t;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
  } vec3_t;

  typedef struct packed {
    logic signed [19:0] px;
    logic signed [19:0] py;
    logic signed [19:0] pz;
    logic signed [15:0] qw;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
  } res_t;

  function automatic logic signed [63:0] round_sh(logic signed [63:0] v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic logic [17:0] div3(logic [18:0] v);
    logic [38:0] m;
    m = 39'(v) * 39'(DIV3_MUL);
    return m[37:20];
  endfunction

  function automatic logic [30:0] horner(logic [30:0] c, logic [30:0] p, logic [16:0] u2);
    logic [47:0] m;
    m = 48'(p) * 48'(u2);
    return 31'(48'(c) - (m >> 16));
  endfunction

  function automatic pos_t len_pos(logic [17:0] l);
    return pos_t'({6'b0, l});
  endfunction

  function automatic pos_t scale(logic [17:0] l, trig_t t, int n);
    logic signed [63:0] m;
    m = 64'(len_pos(l)) * 64'(t);
    return 24'(round_sh(m, n));
  endfunction

  function automatic vec2_t rot2(vec2_t v, trig_t c, trig_t s);
    vec2_t r;
    logic signed [63:0] ax;
    logic signed [63:0] ay;
    ax = 64'(v.x) * 64'(c) - 64'(v.y) * 64'(s);
    ay = 64'(v.x) * 64'(s) + 64'(v.y) * 64'(c);
    r.x = 24'(round_sh(ax, 30));
    r.y = 24'(round_sh(ay, 30));
    return r;
  endfunction

  function automatic vec3_t to_world(vec2_t g, trig_t cy, trig_t sy,
                                     logic signed [19:0] bx, logic [17:0] sh,
                                     logic signed [19:0] bz);
    vec3_t r;
    logic signed [63:0] mx;
    logic signed [63:0] mz;
    mx = 64'(g.x) * 64'(cy);
    mz = -(64'(g.x) * 64'(sy));
    r.x = 24'(round_sh(mx, 30)) + 24'(bx);
    r.y = g.y + len_pos(sh);
    r.z = 24'(round_sh(mz, 30)) + 24'(bz);
    return r;
  endfunction

  function automatic quat_t y_axis_quat(trig_t c, trig_t s);
    quat_t r;
    r.w = 32'(round_sh(64'(c), 2));
    r.x = '0;
    r.y = 32'(round_sh(64'(s), 2));
    r.z = '0;
    return r;
  endfunction

  function automatic quat_t qmul_axis(quat_t a, trig_t c, trig_t s, logic [1:0] axis);
    quat_t r;
    logic signed [63:0] aw, ax, ay, az, bc, bs, w, x, y, z;
    aw = 64'(a.w);
    ax = 64'(a.x);
    ay = 64'(a.y);
    az = 64'(a.z);
    bc = round_sh(64'(c), 2);
    bs = round_sh(64'(s), 2);
    case (axis)
      AXIS_X: begin
        w = aw * bc - ax * bs;
        x = aw * bs + ax * bc;
        y = ay * bc + az * bs;
        z = az * bc - ay * bs;
      end
      AXIS_Y: begin
        w = aw * bc - ay * bs;
        x = ax * bc - az * bs;
        y = aw * bs + ay * bc;
        z = ax * bs + az * bc;
      end
      default: begin
        w = aw * bc - az * bs;
        x = ax * bc + ay * bs;
        y = ay * bc - ax * bs;
        z = aw * bs + az * bc;
      end
    endcase
    r.w = 32'(round_sh(w, 28));
    r.x = 32'(round_sh(x, 28));
    r.y = 32'(round_sh(y, 28));
    r.z = 32'(round_sh(z, 28));
    return r;
  endfunction

  function automatic logic signed [19:0] sat20(pos_t v);
    if (v > 24'sd524287) begin
      return 20'sd524287;
    end else if (v < -24'sd524288) begin
      return -20'sd524288;
    end
    return 20'(v);
  endfunction

  function automatic logic signed [15:0] quant(logic signed [31:0] q);
    logic signed [63:0] r;
    r = round_sh(64'(q), 13);
    if (r > 64'sd32767) begin
      return 16'sd32767;
    end else if (r < -64'sd32767) begin
      return -16'sd32767;
    end
    return 16'(r);
  endfunction

endpackage

/* sv/afk_sin.sv */
// ----------------------------------------------------------------------------
// afk_sin
// Seven-stage sine pipeline: Q0.18 turns in, Q30 out, odd polynomial on
// the quarter wave evaluated one Horner step per stage.
// ----------------------------------------------------------------------------
module afk_sin
  import afk_pkg::*;
(
  input  logic        clk,
  input  logic [17:0] t,
  output trig_t       s
);

  logic [16:0] u_in;
  logic [33:0] sq;
  logic [16:0] u   [1:5];
  logic        neg [1:6];
  logic [16:0] u2  [1:4];
  logic [30:0] p   [2:5];
  logic [30:0] mag;
  logic [47:0] m6;

  always_comb begin
    u_in = t[16] ? 17'(17'd65536 - {1'b0, t[15:0]}) : {1'b0, t[15:0]};
    sq   = 34'(u_in) * 34'(u_in);
    m6   = (48'(p[5]) * 48'(u[5])) >> 16;
  end

  always_ff @(posedge clk) begin
    u[1]   <= u_in;
    neg[1] <= t[17];
    u2[1]  <= sq[32:16];
    p[2]   <= horner(C7, C9, u2[1]);
    p[3]   <= horner(C5, p[2], u2[2]);
    p[4]   <= horner(C3, p[3], u2[3]);
    p[5]   <= horner(C1, p[4], u2[4]);
    mag    <= (m6 > 48'(ONE_Q30)) ? ONE_Q30 : m6[30:0];
    s      <= neg[6] ? -trig_t'({1'b0, mag}) : trig_t'({1'b0, mag});
    for (int i = 2; i <= 5; i++) begin
      u[i] <= u[i-1];
    end
    for (int i = 2; i <= 4; i++) begin
      u2[i] <= u2[i-1];
    end
    for (int i = 2; i <= 6; i++) begin
      neg[i] <= neg[i-1];
    end
  end

endmodule

/* sv/arm_forward_kinematics.sv */
// ----------------------------------------------------------------------------
// arm_forward_kinematics
// Five-joint arm forward kinematics: body centers and orientations.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive the five joint commands and raise start; a transaction is
//   taken at a clock edge with start high and busy low. Busy then stays high
//   after each transaction, so command sets enter no faster than the five
//   results each one produces are read out.
//   Output: five results per command set, body_index 0 to 4, one per cycle
//   on consecutive cycles, each marked by result_valid for one cycle;
//   last_body flags the fifth. The receiver cannot stall.
//   Pipeline: the path is 15 register stages: command and angle registers,
//   a 7-stage sine unit per sine and cosine term, five quaternion product
//   stages, then the result buffer that is read out one body per cycle.
//   Configuration: cfg_ready is always high; write the eight geometry
//   registers only while no command set is in flight.
//   Reset: clears the pipeline valid bits, the busy counter, the readout and the eight geometry registers.
// ----------------------------------------------------------------------------
module arm_forward_kinematics
  import afk_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [15:0]        pan_a_cmd,
  input  logic [15:0]        tilt_a_cmd,
  input  logic [15:0]        tilt_b_cmd,
  input  logic [15:0]        tilt_c_cmd,
  input  logic [15:0]        pan_b_cmd,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [19:0]        cfg_data,
  output logic               result_valid,
  output logic [2:0]         body_index,
  output logic signed [19:0] pos_x,
  output logic signed [19:0] pos_y,
  output logic signed [19:0] pos_z,
  output logic signed [15:0] quat_w,
  output logic signed [15:0] quat_x,
  output logic signed [15:0] quat_y,
  output logic signed [15:0] quat_z,
  output logic               last_body
);

  logic signed [19:0] base_x;
  logic signed [19:0] base_z;
  logic [17:0] shoulder;
  logic [17:0] pan_center;
  logic [17:0] link_a;
  logic [17:0] link_b;
  logic [17:0] link_c;
  logic [17:0] tool;

  logic                  accept;
  logic [2:0]            gap;
  logic [PIPE_DEPTH-1:0] vpipe;

  logic [15:0] c_pa, c_ta, c_tb, c_tc, c_pb;
  logic [17:0] yaw1, ta_f1, tb_f1, tc_f1, pa_h1, ta_h1, tb_h1, tc_h1, pb_h1;
  logic [17:0] tb_m, tc_m;
  logic [17:0] sin_in  [NTRIG];
  trig_t       sin_out [NTRIG];

  quat_t q0_9, q0_10, q0_11, q0_12, q0_13;
  quat_t q1_10, q1_11, q1_12, q1_13;
  quat_t q2_11, q2_12, q2_13;
  quat_t q3_12, q3_13;
  quat_t q4_13;
  vec2_t g1_9, l2_9, p3_9, p4_9;
  vec2_t g1_10, g2_10, l3_10, l4_10;
  vec2_t g1_11, g2_11, g3_11, g4_11;
  vec2_t h3, h4;
  vec3_t w1_12, w2_12, w3_12, w4_12;
  vec3_t w1_13, w2_13, w3_13, w4_13;
  trig_t ca9, sa9, cb9, sb9, cy9, sy9, cta9, sta9, ctb9, stb9, ctc9, stc9, cpb9, spb9;
  trig_t ca10, sa10, cy10, sy10, ctb10, stb10, ctc10, stc10, cpb10, spb10;
  trig_t cy11, sy11, ctc11, stc11, cpb11, spb11;
  trig_t cpb12, spb12;

  logic       active;
  logic [2:0] cnt;
  res_t       obuf [NBODY];
  res_t       cur;

  assign accept    = start && !busy;
  assign busy      = (gap != 3'd0);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_x     <= '0;
      base_z     <= '0;
      shoulder   <= '0;
      pan_center <= '0;
      link_a     <= '0;
      link_b     <= '0;
      link_c     <= '0;
      tool       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BASE_X:     base_x     <= cfg_data;
        REG_BASE_Z:     base_z     <= cfg_data;
        REG_SHOULDER:   shoulder   <= cfg_data[17:0];
        REG_PAN_CENTER: pan_center <= cfg_data[17:0];
        REG_LINK_A:     link_a     <= cfg_data[17:0];
        REG_LINK_B:     link_b     <= cfg_data[17:0];
        REG_LINK_C:     link_c     <= cfg_data[17:0];
        REG_TOOL:       tool       <= cfg_data[17:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gap   <= '0;
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[PIPE_DEPTH-2:0], accept};
      if (accept) begin
        gap <= ACCEPT_GAP;
      end else if (gap != 3'd0) begin
        gap <= gap - 3'd1;
      end
    end
  end

  always_comb begin
    tb_m = 18'({c_tb, 1'b0}) + 18'(c_tb) + 18'd1;
    tc_m = 18'({c_tc, 1'b0}) + 18'(c_tc) + 18'd1;
  end

  always_ff @(posedge clk) begin
    c_pa  <= pan_a_cmd;
    c_ta  <= tilt_a_cmd;
    c_tb  <= tilt_b_cmd;
    c_tc  <= tilt_c_cmd;
    c_pb  <= pan_b_cmd;
    yaw1  <= 18'(BASE_FULL) + {c_pa, 2'b00};
    ta_f1 <= div3({1'b0, c_ta, 2'b00} + 19'd65537);
    ta_h1 <= div3({2'b00, c_ta, 1'b0} + 19'd32769);
    tb_f1 <= 18'({c_tb, 1'b0}) + 18'(c_tb) + 18'd163840;
    tc_f1 <= 18'({c_tc, 1'b0}) + 18'(c_tc) + 18'd163840;
    tb_h1 <= (tb_m >> 1) + 18'd212992;
    tc_h1 <= (tc_m >> 1) + 18'd212992;
    pa_h1 <= {1'b0, c_pa, 1'b0};
    pb_h1 <= {1'b0, c_pb, 1'b0};
  end

  always_comb begin
    sin_in[T_CA]  = ta_f1 + QUARTER;
    sin_in[T_SA]  = ta_f1;
    sin_in[T_CB]  = tb_f1 + QUARTER;
    sin_in[T_SB]  = tb_f1;
    sin_in[T_CC]  = tc_f1 + QUARTER;
    sin_in[T_SC]  = tc_f1;
    sin_in[T_CY]  = yaw1 + QUARTER;
    sin_in[T_SY]  = yaw1;
    sin_in[T_CBH] = 18'(BASE_HALF) + QUARTER;
    sin_in[T_SBH] = 18'(BASE_HALF);
    sin_in[T_CPA] = pa_h1 + QUARTER;
    sin_in[T_SPA] = pa_h1;
    sin_in[T_CTA] = ta_h1 + QUARTER;
    sin_in[T_STA] = ta_h1;
    sin_in[T_CTB] = tb_h1 + QUARTER;
    sin_in[T_STB] = tb_h1;
    sin_in[T_CTC] = tc_h1 + QUARTER;
    sin_in[T_STC] = tc_h1;
    sin_in[T_CPB] = pb_h1 + QUARTER;
    sin_in[T_SPB] = pb_h1;
  end

  for (genvar i = 0; i < NTRIG; i++) begin : g_sin
    afk_sin u_sin (
      .clk (clk),
      .t   (sin_in[i]),
      .s   (sin_out[i])
    );
  end

  // Joint chain: one quaternion product per stage, with the planar link rotations and the world transform alongside.
  always_comb begin
    h3 = rot2(p3_9, cb9, sb9);
    h4 = rot2(p4_9, cb9, sb9);
  end

  always_ff @(posedge clk) begin
    q0_9   <= qmul_axis(y_axis_quat(sin_out[T_CBH], sin_out[T_SBH]),
                        sin_out[T_CPA], sin_out[T_SPA], AXIS_Y);
    g1_9.x <= scale(link_a, sin_out[T_CA], 31);
    g1_9.y <= scale(link_a, sin_out[T_SA], 31);
    l2_9.x <= scale(link_b, sin_out[T_CB], 31) + len_pos(link_a);
    l2_9.y <= scale(link_b, sin_out[T_SB], 31);
    p3_9.x <= scale(link_c, sin_out[T_CC], 30) + len_pos(link_b);
    p3_9.y <= scale(link_c, sin_out[T_SC], 30);
    p4_9.x <= scale(tool, sin_out[T_CC], 30) + len_pos(link_b);
    p4_9.y <= scale(tool, sin_out[T_SC], 30);
    ca9    <= sin_out[T_CA];
    sa9    <= sin_out[T_SA];
    cb9    <= sin_out[T_CB];
    sb9    <= sin_out[T_SB];
    cy9    <= sin_out[T_CY];
    sy9    <= sin_out[T_SY];
    cta9   <= sin_out[T_CTA];
    sta9   <= sin_out[T_STA];
    ctb9   <= sin_out[T_CTB];
    stb9   <= sin_out[T_STB];
    ctc9   <= sin_out[T_CTC];
    stc9   <= sin_out[T_STC];
    cpb9   <= sin_out[T_CPB];
    spb9   <= sin_out[T_SPB];

    q0_10   <= q0_9;
    q1_10   <= qmul_axis(q0_9, cta9, sta9, AXIS_Z);
    g1_10   <= g1_9;
    g2_10   <= rot2(l2_9, ca9, sa9);
    l3_10.x <= h3.x + len_pos(link_a);
    l3_10.y <= h3.y;
    l4_10.x <= h4.x + len_pos(link_a);
    l4_10.y <= h4.y;
    ca10    <= ca9;
    sa10    <= sa9;
    cy10    <= cy9;
    sy10    <= sy9;
    ctb10   <= ctb9;
    stb10   <= stb9;
    ctc10   <= ctc9;
    stc10   <= stc9;
    cpb10   <= cpb9;
    spb10   <= spb9;

    q0_11 <= q0_10;
    q1_11 <= q1_10;
    q2_11 <= qmul_axis(q1_10, ctb10, stb10, AXIS_Z);
    g1_11 <= g1_10;
    g2_11 <= g2_10;
    g3_11 <= rot2(l3_10, ca10, sa10);
    g4_11 <= rot2(l4_10, ca10, sa10);
    cy11  <= cy10;
    sy11  <= sy10;
    ctc11 <= ctc10;
    stc11 <= stc10;
    cpb11 <= cpb10;
    spb11 <= spb10;

    q0_12 <= q0_11;
    q1_12 <= q1_11;
    q2_12 <= q2_11;
    q3_12 <= qmul_axis(q2_11, ctc11, stc11, AXIS_Z);
    w1_12 <= to_world(g1_11, cy11, sy11, base_x, shoulder, base_z);
    w2_12 <= to_world(g2_11, cy11, sy11, base_x, shoulder, base_z);
    w3_12 <= to_world(g3_11, cy11, sy11, base_x, shoulder, base_z);
    w4_12 <= to_world(g4_11, cy11, sy11, base_x, shoulder, base_z);
    cpb12 <= cpb11;
    spb12 <= spb11;

    q0_13 <= q0_12;
    q1_13 <= q1_12;
    q2_13 <= q2_12;
    q3_13 <= q3_12;
    q4_13 <= qmul_axis(q3_12, cpb12, spb12, AXIS_X);
    w1_13 <= w1_12;
    w2_13 <= w2_12;
    w3_13 <= w3_12;
    w4_13 <= w4_12;
  end

  always_ff @(posedge clk) begin
    if (vpipe[PIPE_DEPTH-1]) begin
      obuf[0] <= '{px: base_x, py: 20'(pan_center), pz: base_z,
                   qw: quant(q0_13.w), qx: quant(q0_13.x),
                   qy: quant(q0_13.y), qz: quant(q0_13.z)};
      obuf[1] <= '{px: sat20(w1_13.x), py: sat20(w1_13.y), pz: sat20(w1_13.z),
                   qw: quant(q1_13.w), qx: quant(q1_13.x),
                   qy: quant(q1_13.y), qz: quant(q1_13.z)};
      obuf[2] <= '{px: sat20(w2_13.x), py: sat20(w2_13.y), pz: sat20(w2_13.z),
                   qw: quant(q2_13.w), qx: quant(q2_13.x),
                   qy: quant(q2_13.y), qz: quant(q2_13.z)};
      obuf[3] <= '{px: sat20(w3_13.x), py: sat20(w3_13.y), pz: sat20(w3_13.z),
                   qw: quant(q3_13.w), qx: quant(q3_13.x),
                   qy: quant(q3_13.y), qz: quant(q3_13.z)};
      obuf[4] <= '{px: sat20(w4_13.x), py: sat20(w4_13.y), pz: sat20(w4_13.z),
                   qw: quant(q4_13.w), qx: quant(q4_13.x),
                   qy: quant(q4_13.y), qz: quant(q4_13.z)};
    end
  end

  // Readout: advance one body per cycle after each buffer load.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
    end else if (vpipe[PIPE_DEPTH-1]) begin
      active <= 1'b1;
      cnt    <= '0;
    end else if (active) begin
      if (cnt == BODY_LAST) begin
        active <= 1'b0;
        cnt    <= '0;
      end else begin
        cnt <= cnt + 3'd1;
      end
    end
  end

  assign cur          = obuf[cnt];
  assign result_valid = active;
  assign body_index   = cnt;
  assign last_body    = active && (cnt == BODY_LAST);
  assign pos_x        = cur.px;
  assign pos_y        = cur.py;
  assign pos_z        = cur.pz;
  assign quat_w       = cur.qw;
  assign quat_x       = cur.qx;
  assign quat_y       = cur.qy;
  assign quat_z       = cur.qz;

endmodule

/* sv/afk_checker.sv */
// ----------------------------------------------------------------------------
// afk_checker
// Port-level checks of the arm forward kinematics block, bound to the top.
// ----------------------------------------------------------------------------
module afk_checker
  import afk_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       result_valid,
  input logic [2:0] body_index,
  input logic       last_body
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after transaction");

  a_body_seq: assert property (@(posedge clk) disable iff (rst)
    result_valid && (body_index != BODY_LAST) |=>
      result_valid && (body_index == $past(body_index) + 3'd1))
    else $error("result sequence broken");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    last_body == (result_valid && (body_index == BODY_LAST)))
    else $error("last_body mismatch");

  a_reset: assert property (@(posedge clk)
    rst |=> !result_valid && !busy)
    else $error("outputs active after reset");

endmodule

bind arm_forward_kinematics afk_checker u_afk_checker (.*);

/* tb/tb_arm_forward_kinematics.sv */
// ----------------------------------------------------------------------------
// tb_arm_forward_kinematics
// Self-checking testbench for the arm forward kinematics block. It predicts
// the five body poses of each accepted joint command set in fixed point,
// queues them and compares every result strobe field by field. It covers
// directed joint extremes, saturating geometry and random configurations
// with random sender idling.
// ----------------------------------------------------------------------------
module tb_arm_forward_kinematics;
  import afk_pkg::*;

  localparam longint unsigned TRIG_ONE = 64'd1073741824;
  localparam int DRAIN_CYCLES = 24;

  typedef struct {
    logic [2:0]         body;
    logic signed [19:0] px;
    logic signed [19:0] py;
    logic signed [19:0] pz;
    logic signed [15:0] qw;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic               last;
  } pose_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [15:0]        pan_a_cmd = '0;
  logic [15:0]        tilt_a_cmd = '0;
  logic [15:0]        tilt_b_cmd = '0;
  logic [15:0]        tilt_c_cmd = '0;
  logic [15:0]        pan_b_cmd = '0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [19:0]        cfg_data = '0;
  logic               result_valid;
  logic [2:0]         body_index;
  logic signed [19:0] pos_x;
  logic signed [19:0] pos_y;
  logic signed [19:0] pos_z;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic               last_body;

  pose_t       pose_queue[$];
  int          mismatches = 0;
  bit          idle_on = 1'b1;
  longint      geo_base_x = 0;
  longint      geo_base_z = 0;
  longint      geo_shoulder = 0;
  longint      geo_pan_center = 0;
  longint      geo_link_a = 0;
  longint      geo_link_b = 0;
  longint      geo_link_c = 0;
  longint      geo_tool = 0;

  arm_forward_kinematics dut (.*);

  always #5 clk = ~clk;

  function automatic longint rnd(longint v, int n);
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint sin_quarter(longint unsigned u);
    longint unsigned u2;
    longint unsigned p;
    u2 = (u * u) >> 16;
    p = 64'(C9);
    p = 64'(C7) - ((p * u2) >> 16);
    p = 64'(C5) - ((p * u2) >> 16);
    p = 64'(C3) - ((p * u2) >> 16);
    p = 64'(C1) - ((p * u2) >> 16);
    p = (p * u) >> 16;
    if (p > TRIG_ONE) p = TRIG_ONE;
    return longint'(p);
  endfunction

  function automatic longint sine(int unsigned t);
    int unsigned quad;
    int unsigned frac;
    longint s;
    t = t & 32'h3FFFF;
    quad = t >> 16;
    frac = t & 32'hFFFF;
    if (quad[0]) frac = 65536 - frac;
    s = sin_quarter(frac);
    return quad[1] ? -s : s;
  endfunction

  function automatic longint cosine(int unsigned t);
    return sine(t + 65536);
  endfunction

  typedef longint quat4_t[4];

  function automatic quat4_t hamilton(quat4_t a, quat4_t b);
    quat4_t r;
    r[0] = rnd(a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3], 28);
    r[1] = rnd(a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2], 28);
    r[2] = rnd(a[0]*b[2] - a[1]*b[3] + a[2]*b[0] + a[3]*b[1], 28);
    r[3] = rnd(a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0], 28);
    return r;
  endfunction

  function automatic quat4_t joint_quat(int axis, int unsigned half);
    quat4_t q;
    q = '{rnd(cosine(half), 2), 0, 0, 0};
    q[1 + axis] = rnd(sine(half), 2);
    return q;
  endfunction

  function automatic pose_t make_pose(int k, longint x, longint y, longint z, quat4_t q);
    pose_t p;
    p.body = 3'(k);
    p.px = 20'(clamp(x, -524288, 524287));
    p.py = 20'(clamp(y, -524288, 524287));
    p.pz = 20'(clamp(z, -524288, 524287));
    p.qw = 16'(clamp(rnd(q[0], 13), -32767, 32767));
    p.qx = 16'(clamp(rnd(q[1], 13), -32767, 32767));
    p.qy = 16'(clamp(rnd(q[2], 13), -32767, 32767));
    p.qz = 16'(clamp(rnd(q[3], 13), -32767, 32767));
    p.last = (k == 4);
    return p;
  endfunction

  task automatic predict_poses(int unsigned ca, int unsigned ct, int unsigned cb,
                               int unsigned cc, int unsigned cp);
    int unsigned ta_full, ta_half, tb_full, tb_half, tc_full, tc_half, yaw;
    longint ctA, stA, ctB, stB, ctC, stC, cyw, syw;
    longint lx, ly, gx, gy, hx, hy, px, py, len;
    quat4_t q[5];
    ta_full = (4 * ct + 65537) / 3;
    ta_half = (2 * ct + 32769) / 3;
    tb_full = (3 * cb + 262144 - 98304) & 32'h3FFFF;
    tb_half = (((3 * cb + 1) >> 1) + 262144 - 49152) & 32'h3FFFF;
    tc_full = (3 * cc + 262144 - 98304) & 32'h3FFFF;
    tc_half = (((3 * cc + 1) >> 1) + 262144 - 49152) & 32'h3FFFF;
    yaw = (BASE_FULL + (ca << 2)) & 32'h3FFFF;
    ctA = cosine(ta_full); stA = sine(ta_full);
    ctB = cosine(tb_full); stB = sine(tb_full);
    ctC = cosine(tc_full); stC = sine(tc_full);
    cyw = cosine(yaw); syw = sine(yaw);
    q[0] = hamilton(joint_quat(1, BASE_HALF), joint_quat(1, ca << 1));
    q[1] = hamilton(q[0], joint_quat(2, ta_half));
    q[2] = hamilton(q[1], joint_quat(2, tb_half));
    q[3] = hamilton(q[2], joint_quat(2, tc_half));
    q[4] = hamilton(q[3], joint_quat(0, cp << 1));
    pose_queue.push_back(make_pose(0, geo_base_x, geo_pan_center, geo_base_z, q[0]));
    for (int k = 1; k < 5; k++) begin
      if (k == 1) begin
        gx = rnd(geo_link_a * ctA, 31);
        gy = rnd(geo_link_a * stA, 31);
      end else begin
        if (k == 2) begin
          lx = rnd(geo_link_b * ctB, 31) + geo_link_a;
          ly = rnd(geo_link_b * stB, 31);
        end else begin
          len = (k == 3) ? geo_link_c : geo_tool;
          px = rnd(len * ctC, 30) + geo_link_b;
          py = rnd(len * stC, 30);
          hx = rnd(px * ctB - py * stB, 30);
          hy = rnd(px * stB + py * ctB, 30);
          lx = hx + geo_link_a;
          ly = hy;
        end
        gx = rnd(lx * ctA - ly * stA, 30);
        gy = rnd(lx * stA + ly * ctA, 30);
      end
      pose_queue.push_back(make_pose(k, rnd(gx * cyw, 30) + geo_base_x,
                                     gy + geo_shoulder,
                                     rnd(-gx * syw, 30) + geo_base_z, q[k]));
    end
  endtask

  always @(posedge clk) begin
    pose_t e;
    if (!rst && result_valid) begin
      if (pose_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result body %0d", body_index);
      end else begin
        e = pose_queue.pop_front();
        if (body_index !== e.body || pos_x !== e.px || pos_y !== e.py ||
            pos_z !== e.pz || quat_w !== e.qw || quat_x !== e.qx ||
            quat_y !== e.qy || quat_z !== e.qz || last_body !== e.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch exp: b=%0d p=(%0d,%0d,%0d) q=(%0d,%0d,%0d,%0d) l=%0b",
                     e.body, e.px, e.py, e.pz, e.qw, e.qx, e.qy, e.qz, e.last);
            $display("         act: b=%0d p=(%0d,%0d,%0d) q=(%0d,%0d,%0d,%0d) l=%0b",
                     body_index, pos_x, pos_y, pos_z, quat_w, quat_x, quat_y,
                     quat_z, last_body);
          end
        end
      end
    end
  end

  task automatic idle_burst();
    if (idle_on && $urandom_range(0, 2) == 0) repeat ($urandom_range(1, 10)) @(negedge clk);
  endtask

  task automatic send_cmd(logic [15:0] ca, logic [15:0] ct, logic [15:0] cb,
                          logic [15:0] cc, logic [15:0] cp);
    idle_burst();
    pan_a_cmd = ca;
    tilt_a_cmd = ct;
    tilt_b_cmd = cb;
    tilt_c_cmd = cc;
    pan_b_cmd = cp;
    start = 1'b1;
    @(posedge clk);
    while (busy) begin
      @(negedge clk);
      @(posedge clk);
    end
    predict_poses(ca, ct, cb, cc, cp);
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic send_random();
    send_cmd(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic wait_drained();
    while (pose_queue.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [19:0] data);
    idle_burst();
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) begin
      @(negedge clk);
      @(posedge clk);
    end
    case (idx)
      REG_BASE_X:     geo_base_x = longint'(signed'(data));
      REG_BASE_Z:     geo_base_z = longint'(signed'(data));
      REG_SHOULDER:   geo_shoulder = data[17:0];
      REG_PAN_CENTER: geo_pan_center = data[17:0];
      REG_LINK_A:     geo_link_a = data[17:0];
      REG_LINK_B:     geo_link_b = data[17:0];
      REG_LINK_C:     geo_link_c = data[17:0];
      default:        geo_tool = data[17:0];
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic write_geometry(logic [19:0] bx, logic [19:0] bz, logic [19:0] sh,
                                logic [19:0] pc, logic [19:0] la, logic [19:0] lb,
                                logic [19:0] lc, logic [19:0] tl);
    wait_drained();
    write_reg(REG_BASE_X, bx);
    write_reg(REG_BASE_Z, bz);
    write_reg(REG_SHOULDER, sh);
    write_reg(REG_PAN_CENTER, pc);
    write_reg(REG_LINK_A, la);
    write_reg(REG_LINK_B, lb);
    write_reg(REG_LINK_C, lc);
    write_reg(REG_TOOL, tl);
  endtask

  task automatic test_reset_geometry();
    send_cmd(16'h1234, 16'h8000, 16'h4000, 16'hC000, 16'h0F0F);
  endtask

  task automatic test_joint_extremes();
    logic [15:0] corner[4];
    corner = '{16'h0000, 16'hFFFF, 16'h8000, 16'h5555};
    write_geometry(20'd2560, -20'sd2560, 20'd12800, 20'd6400, 20'd25600,
                   20'd19200, 20'd6400, 20'd16000);
    for (int i = 0; i < 4; i++) send_cmd(corner[i], corner[i], corner[i], corner[i], corner[i]);
    send_cmd(16'h4000, 16'h0000, 16'hFFFF, 16'h0000, 16'hC000);
    send_cmd(16'hC000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h4000);
    send_cmd(16'h2000, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h0001);
    send_cmd(16'hFFFE, 16'h0001, 16'h8000, 16'h8000, 16'hFFFE);
  endtask

  task automatic test_saturation();
    write_geometry(20'h7FFFF, 20'h80000, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF,
                   20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
    send_cmd(16'h0000, 16'hFFFF, 16'h8000, 16'h8000, 16'h0000);
    send_cmd(16'h8000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_cmd(16'h4000, 16'h8000, 16'h0000, 16'h0000, 16'h8000);
    write_geometry(20'h80000, 20'h7FFFF, 20'h0, 20'h0, 20'h3FFFF,
                   20'h0, 20'h3FFFF, 20'h0);
    send_cmd(16'h8000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h2000);
    send_cmd(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
  endtask

  task automatic test_random_geometry();
    for (int phase = 0; phase < 4; phase++) begin
      write_geometry(20'($urandom), 20'($urandom), 20'($urandom), 20'($urandom),
                     20'($urandom), 20'($urandom), 20'($urandom), 20'($urandom));
      repeat (20) send_random();
    end
    idle_on = 1'b0;
    write_geometry(20'($urandom_range(0, 4095)), -20'sd1000, 20'd20000, 20'd9000,
                   20'd30000, 20'd25000, 20'd8000, 20'd18000);
    repeat (20) send_random();
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst = 1'b0;
    test_reset_geometry();
    test_joint_extremes();
    test_saturation();
    test_random_geometry();
    wait_drained();
    if (mismatches == 0 && pose_queue.size() == 0) begin
      $display("tb_arm_forward_kinematics passed");
    end else begin
      $display("tb_arm_forward_kinematics failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_arm_forward_kinematics failed");
    $finish;
  end

endmodule
